FILE: hdl/acc_pkg.sv
// Package: shared types, constants and month table for the Advent candle counter.
`timescale 1ns / 1ps

package acc_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned LIT_W   = 3;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned SUM_W   = 15;
  localparam int unsigned PROD_W  = 27;
  localparam int unsigned Q100_W  = 8;

  // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [6:0]  CENTURY     = 7'd100;

  localparam logic [DAY_W-1:0]   DEC_ANCHOR_DAY = 5'd24;
  localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_MAR      = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
  localparam logic [DOY_W-1:0]   DAYS_TO_DEC    = 9'd334;
  localparam logic [DOY_W-1:0]   WEEK           = 9'd7;

  typedef struct packed {
    logic                valid;
    logic [SUM_W-1:0]    wk_sum;
    logic                leap;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
  } yr_stage_t;

  typedef struct packed {
    logic                valid;
    logic [DAY_W-1:0]    fourth;
    logic [DOY_W-1:0]    doy;
    logic                leap;
  } cal_stage_t;

  // days before the first of the month in a common year; out-of-range months add none
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/acc_year_div.sv
// Year stages: century quotient by reciprocal, leap flag and weekday sum.
`timescale 1ns / 1ps

module acc_year_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [acc_pkg::YEAR_W-1:0]    year,
  input  logic [acc_pkg::MONTH_W-1:0]   month,
  input  logic [acc_pkg::DAY_W-1:0]     day,
  output acc_pkg::yr_stage_t            yr_out
);

  logic                          s1_valid_r;
  logic [acc_pkg::YEAR_W-1:0]    s1_year_r;
  logic [acc_pkg::MONTH_W-1:0]   s1_month_r;
  logic [acc_pkg::DAY_W-1:0]     s1_day_r;
  logic [acc_pkg::PROD_W-1:0]    s1_prod_r;
  logic [acc_pkg::PROD_W-1:0]    s1_prod_nxt;

  logic [acc_pkg::Q100_W-1:0]    q100;
  logic [acc_pkg::YEAR_W-1:0]    r100;
  logic                          leap;
  logic [acc_pkg::SUM_W-1:0]     wk_sum;
  acc_pkg::yr_stage_t            s2_r;
  acc_pkg::yr_stage_t            s2_nxt;

  assign s1_prod_nxt = acc_pkg::PROD_W'(year) * acc_pkg::PROD_W'(acc_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_year_r  <= year;
      s1_month_r <= month;
      s1_day_r   <= day;
      s1_prod_r  <= s1_prod_nxt;
    end
  end

  always_comb begin
    q100 = s1_prod_r[acc_pkg::RECIP_SHIFT +: acc_pkg::Q100_W];
    r100 = s1_year_r - acc_pkg::YEAR_W'(q100 * acc_pkg::CENTURY);
    // divisible by 4 and not by 100, or divisible by 400
    leap = ((s1_year_r[1:0] == 2'd0) && (r100 != '0)) ||
           ((r100 == '0) && (q100[1:0] == 2'd0));
    // y + y/4 - y/100 + y/400; the table and anchor terms add 28, a whole week
    wk_sum = acc_pkg::SUM_W'(s1_year_r) + acc_pkg::SUM_W'(s1_year_r[acc_pkg::YEAR_W-1:2])
           - acc_pkg::SUM_W'(q100) + acc_pkg::SUM_W'(q100[acc_pkg::Q100_W-1:2]);
    s2_nxt.valid  = s1_valid_r;
    s2_nxt.wk_sum = wk_sum;
    s2_nxt.leap   = leap;
    s2_nxt.month  = s1_month_r;
    s2_nxt.day    = s1_day_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign yr_out = s2_r;

endmodule

FILE: hdl/acc_calendar.sv
// Calendar stage: weekday of December 24 by octal folding, fourth Sunday, day of year.
`timescale 1ns / 1ps

module acc_calendar (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  acc_pkg::yr_stage_t    yr_in,
  output acc_pkg::cal_stage_t   cal_out
);

  logic [5:0]                    fold1;
  logic [3:0]                    fold2;
  logic [2:0]                    wday;
  logic [acc_pkg::DOY_W-1:0]     doy;
  logic                          leap_add;
  acc_pkg::cal_stage_t           s3_r;
  acc_pkg::cal_stage_t           s3_nxt;

  always_comb begin
    // 8 = 1 mod 7, so summing octal digits keeps the residue
    fold1 = 6'(yr_in.wk_sum[2:0]) + 6'(yr_in.wk_sum[5:3]) + 6'(yr_in.wk_sum[8:6])
          + 6'(yr_in.wk_sum[11:9]) + 6'(yr_in.wk_sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    wday  = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    leap_add = yr_in.leap && (yr_in.month >= acc_pkg::MONTH_MAR) &&
               (yr_in.month <= acc_pkg::MONTH_DEC);
    doy = acc_pkg::days_before(yr_in.month) + acc_pkg::DOY_W'(yr_in.day)
        + acc_pkg::DOY_W'(leap_add);

    s3_nxt.valid  = yr_in.valid;
    s3_nxt.fourth = acc_pkg::DEC_ANCHOR_DAY - acc_pkg::DAY_W'(wday);
    s3_nxt.doy    = doy;
    s3_nxt.leap   = yr_in.leap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s3_r <= s3_nxt;
    end
  end

  assign cal_out = s3_r;

endmodule

FILE: hdl/acc_candle.sv
// Count stage: compare day of year with the four Advent Sundays; output register.
`timescale 1ns / 1ps

module acc_candle (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  acc_pkg::cal_stage_t         cal_in,
  output logic                        out_valid,
  output logic [acc_pkg::LIT_W-1:0]   candles_lit,
  output logic [acc_pkg::DAY_W-1:0]   fourth_advent_day,
  output logic [acc_pkg::DOY_W-1:0]   day_of_year
);

  logic [acc_pkg::DOY_W-1:0]  f4;
  logic [acc_pkg::DOY_W-1:0]  f3;
  logic [acc_pkg::DOY_W-1:0]  f2;
  logic [acc_pkg::DOY_W-1:0]  f1;
  logic [acc_pkg::LIT_W-1:0]  lit_nxt;

  logic                       valid_r;
  logic [acc_pkg::LIT_W-1:0]  lit_r;
  logic [acc_pkg::DAY_W-1:0]  fourth_r;
  logic [acc_pkg::DOY_W-1:0]  doy_r;

  always_comb begin
    f4 = acc_pkg::DAYS_TO_DEC + acc_pkg::DOY_W'(cal_in.fourth) + acc_pkg::DOY_W'(cal_in.leap);
    f3 = f4 - acc_pkg::WEEK;
    f2 = f3 - acc_pkg::WEEK;
    f1 = f2 - acc_pkg::WEEK;
    if (cal_in.doy >= f4) begin
      lit_nxt = 3'd4;
    end else if (cal_in.doy >= f3) begin
      lit_nxt = 3'd3;
    end else if (cal_in.doy >= f2) begin
      lit_nxt = 3'd2;
    end else if (cal_in.doy >= f1) begin
      lit_nxt = 3'd1;
    end else begin
      lit_nxt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= cal_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lit_r    <= lit_nxt;
      fourth_r <= cal_in.fourth;
      doy_r    <= cal_in.doy;
    end
  end

  assign out_valid         = valid_r;
  assign candles_lit       = lit_r;
  assign fourth_advent_day = fourth_r;
  assign day_of_year       = doy_r;

endmodule

FILE: hdl/advent_candle_count_unit.sv
// Top level: Advent candle counter, four-stage streaming pipeline.
//
// Usage:
//   Input channel in_*: one date per transaction, year/month/day packed in
//   in_tdata. Output channel out_*: one result per date, in the same order,
//   carrying the candle count, the December day of the fourth Advent Sunday
//   and the ordinal day of the date.
//   Stages: century multiply, leap and weekday sum, mod-7 fold and day of
//   year, Sunday compares into the output register.
//   Throughput: one date per cycle while the output is not stalled; no stage
//   iterates, every stage is one register deep.
//   Stall: the whole pipeline advances only when the output register is
//   empty or being taken; while out_tready is low with a result waiting,
//   in_tready drops and every stage holds, so nothing is lost or repeated.
//   Reset: synchronous, active low; clears the stage valid flags only. There
//   is no control state beyond them; the data registers are not reset.
`timescale 1ns / 1ps

module advent_candle_count_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [13:0] year, [17:14] month, [22:18] day, [23] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [2:0] candles_lit, [7:3] fourth_advent_day,
                                  // [16:8] day_of_year, [23:17] zero
);

  logic                          en;
  acc_pkg::yr_stage_t            yr_stage;
  acc_pkg::cal_stage_t           cal_stage;
  logic [acc_pkg::LIT_W-1:0]     candles_lit;
  logic [acc_pkg::DAY_W-1:0]     fourth_advent_day;
  logic [acc_pkg::DOY_W-1:0]     day_of_year;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  acc_year_div u_year_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .year     (in_tdata[13:0]),
    .month    (in_tdata[17:14]),
    .day      (in_tdata[22:18]),
    .yr_out   (yr_stage)
  );

  acc_calendar u_calendar (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .yr_in   (yr_stage),
    .cal_out (cal_stage)
  );

  acc_candle u_candle (
    .clk               (clk),
    .rst_n             (rst_n),
    .en                (en),
    .cal_in            (cal_stage),
    .out_valid         (out_tvalid),
    .candles_lit       (candles_lit),
    .fourth_advent_day (fourth_advent_day),
    .day_of_year       (day_of_year)
  );

  assign out_tdata = {7'd0, day_of_year, fourth_advent_day, candles_lit};

endmodule

FILE: test/advent_candle_count_checker.sv
// Checker: watches both channels of the Advent candle counter, predicts and compares each result.
`timescale 1ns / 1ps

module advent_candle_count_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [13:0] year, [17:14] month, [22:18] day, [23] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [2:0] candles_lit, [7:3] fourth_advent_day,
                                  // [16:8] day_of_year, [23:17] zero
  output int          fail_count,
  output int          outstanding
);

  typedef struct packed {
    logic [acc_pkg::LIT_W-1:0] lit;
    logic [acc_pkg::DAY_W-1:0] fourth;
    logic [acc_pkg::DOY_W-1:0] doy;
  } candle_result_t;

  // Sakamoto table entry for December
  localparam int unsigned SAKAMOTO_DEC = 4;
  localparam int unsigned MONTH_START [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                               304, 334};

  candle_result_t expected_q [$];
  int errors  = 0;
  int pending = 0;

  assign fail_count  = errors;
  assign outstanding = pending;

  function automatic int unsigned ordinal(input int unsigned y, input int unsigned m,
                                          input int unsigned d);
    int unsigned n;
    logic        leap;
    n    = d;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m >= acc_pkg::MONTH_JAN && m <= acc_pkg::MONTH_DEC) begin
      n += MONTH_START[m - 1];
      if (m >= acc_pkg::MONTH_MAR && leap) n += 1;
    end
    return n;
  endfunction

  function automatic candle_result_t advent_candles(
      input logic [acc_pkg::YEAR_W-1:0]  year,
      input logic [acc_pkg::MONTH_W-1:0] month,
      input logic [acc_pkg::DAY_W-1:0]   day);
    int unsigned    y, wd, fourth, sun4, doy;
    candle_result_t r;
    y      = year;
    wd     = (y + y / 4 - y / 100 + y / 400 + SAKAMOTO_DEC + acc_pkg::DEC_ANCHOR_DAY)
             % acc_pkg::WEEK;
    fourth = acc_pkg::DEC_ANCHOR_DAY - wd;
    sun4   = ordinal(y, acc_pkg::MONTH_DEC, fourth);
    doy    = ordinal(y, month, day);
    if (doy >= sun4)                          r.lit = 3'd4;
    else if (doy >= sun4 - acc_pkg::WEEK)     r.lit = 3'd3;
    else if (doy >= sun4 - 2 * acc_pkg::WEEK) r.lit = 3'd2;
    else if (doy >= sun4 - 3 * acc_pkg::WEEK) r.lit = 3'd1;
    else                                      r.lit = 3'd0;
    r.fourth = fourth[acc_pkg::DAY_W-1:0];
    r.doy    = doy[acc_pkg::DOY_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    candle_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %h", $time,
                   out_tdata);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          pending--;
          if (out_tdata[2:0] !== exp_r.lit) begin
            $display("%0t: candles_lit expected %0d, got %0d", $time, exp_r.lit,
                     out_tdata[2:0]);
            errors++;
          end
          if (out_tdata[7:3] !== exp_r.fourth) begin
            $display("%0t: fourth_advent_day expected %0d, got %0d", $time, exp_r.fourth,
                     out_tdata[7:3]);
            errors++;
          end
          if (out_tdata[16:8] !== exp_r.doy) begin
            $display("%0t: day_of_year expected %0d, got %0d", $time, exp_r.doy,
                     out_tdata[16:8]);
            errors++;
          end
          if (out_tdata[23:17] !== 7'd0) begin
            $display("%0t: padding expected 0, got %h", $time, out_tdata[23:17]);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(advent_candles(in_tdata[13:0], in_tdata[17:14],
                                            in_tdata[22:18]));
        pending++;
      end
    end
  end

endmodule

FILE: test/tb_advent_candle_count_unit.sv
// Testbench top: clock, reset, date stimulus under varied flow control, and the verdict.
`timescale 1ns / 1ps

module tb_advent_candle_count_unit;

  typedef enum {PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} flow_phase_t;

  localparam int HEAVY_PCT      = 74;
  localparam int LIGHT_PCT      = 11;
  localparam int DATES_PER_PHASE = 440;
  localparam int CYCLE_LIMIT    = 200000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  int          fail_count;
  int          outstanding;
  int          idle_pct   = 0;
  int          stall_pct  = 0;

  always #6 clk = ~clk;

  advent_candle_count_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  advent_candle_count_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic set_flow(input flow_phase_t ph);
    case (ph)
      PH_FREE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      PH_SEND_IDLE: begin
        idle_pct  = HEAVY_PCT;
        stall_pct = 0;
      end
      PH_RECV_STALL: begin
        idle_pct  = 0;
        stall_pct = HEAVY_PCT;
      end
      default: begin
        idle_pct  = LIGHT_PCT;
        stall_pct = LIGHT_PCT;
      end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_date(input logic [acc_pkg::YEAR_W-1:0] y,
                           input logic [acc_pkg::MONTH_W-1:0] m,
                           input logic [acc_pkg::DAY_W-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, d, m, y};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random_date;
    logic [acc_pkg::YEAR_W-1:0]  y;
    logic [acc_pkg::MONTH_W-1:0] m;
    logic [acc_pkg::DAY_W-1:0]   d;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        // the Advent season and its surroundings
        y = acc_pkg::YEAR_W'($urandom_range(9999, 1));
        m = $urandom_range(1) ? acc_pkg::MONTH_DEC : acc_pkg::MONTH_DEC - 4'd1;
        d = acc_pkg::DAY_W'($urandom_range(31, 1));
      end
      4, 5, 6, 7: begin
        y = acc_pkg::YEAR_W'($urandom_range(9999, 1));
        m = acc_pkg::MONTH_W'($urandom_range(acc_pkg::MONTH_DEC, acc_pkg::MONTH_JAN));
        d = acc_pkg::DAY_W'($urandom_range(31, 1));
      end
      8: begin
        y = acc_pkg::YEAR_W'($urandom_range(16383, 0));
        m = acc_pkg::MONTH_W'($urandom_range(15, 0));
        d = acc_pkg::DAY_W'($urandom_range(31, 0));
      end
      default: begin
        // century years, where the leap rule bites
        y = acc_pkg::YEAR_W'($urandom_range(163, 0) * 100);
        m = acc_pkg::MONTH_W'($urandom_range(acc_pkg::MONTH_DEC, acc_pkg::MONTH_JAN));
        d = acc_pkg::DAY_W'($urandom_range(31, 0));
      end
    endcase
    send_date(y, m, d);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("advent_candle_count_unit test failed");
    $finish;
  end

  initial begin
    flow_phase_t ph;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_flow(PH_FREE);
    // Sunday on 24 December: fourth Advent on the 24th
    send_date(14'd2023, acc_pkg::MONTH_DEC, 5'd24);
    send_date(14'd2023, acc_pkg::MONTH_DEC, 5'd23);
    send_date(14'd2023, acc_pkg::MONTH_DEC, 5'd3);
    send_date(14'd2023, acc_pkg::MONTH_DEC, 5'd2);
    // Saturday on 24 December: fourth Advent on the 18th
    send_date(14'd2022, acc_pkg::MONTH_DEC, 5'd18);
    send_date(14'd2022, acc_pkg::MONTH_DEC - 4'd1, 5'd27);
    send_date(14'd2022, acc_pkg::MONTH_DEC - 4'd1, 5'd26);
    send_date(14'd2024, acc_pkg::MONTH_DEC, 5'd31);
    send_date(14'd2023, acc_pkg::MONTH_DEC, 5'd31);
    send_date(14'd2000, acc_pkg::MONTH_MAR, 5'd1);
    send_date(14'd1900, acc_pkg::MONTH_MAR, 5'd1);
    send_date(14'd2024, acc_pkg::MONTH_MAR - 4'd1, 5'd29);
    send_date(14'd1, acc_pkg::MONTH_JAN, 5'd1);
    send_date(14'd9999, acc_pkg::MONTH_DEC, 5'd31);
    // year zero and the top of the year field
    send_date(14'd0, acc_pkg::MONTH_DEC, 5'd25);
    send_date(14'h3FFF, acc_pkg::MONTH_DEC, 5'd31);
    // months outside 1..12 behave as January
    send_date(14'd2021, 4'd0, 5'd17);
    send_date(14'd2021, 4'd13, 5'd31);
    send_date(14'd2024, 4'd15, 5'd0);
    // day zero and days beyond the month length
    send_date(14'd2024, acc_pkg::MONTH_MAR, 5'd0);
    send_date(14'd2023, 4'd4, 5'd31);
    send_date(14'd2023, acc_pkg::MONTH_JAN, 5'd0);
    send_date(14'h2AAA, 4'd10, 5'd21);
    send_date(14'h1555, 4'd5, 5'd10);
    drain();

    for (int p = 0; p < 4; p++) begin
      ph = flow_phase_t'(p);
      set_flow(ph);
      for (int i = 0; i < DATES_PER_PHASE; i++) begin
        send_random_date();
        if (i == DATES_PER_PHASE / 2) drain();
      end
      drain();
    end

    set_flow(PH_FREE);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("advent_candle_count_unit test passed");
    end else begin
      $display("advent_candle_count_unit test failed");
    end
    $finish;
  end

endmodule
